// ===== rtl/core/llga_pkg.sv =====
// shared types, command codes and neighbour rule for the grid automaton
package llga_pkg;

  // default grid size
  localparam int GRID_ROWS_DEF = 128;
  localparam int GRID_COLS_DEF = 128;

  // queue depths between the sides
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  // field widths
  localparam int CMD_W  = 3;
  localparam int ADDR_W = 7;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WIPE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // neighbour rule: birth on 2 to 4 of 8, no survivors
  localparam int         NB_COUNT     = 8;
  localparam logic [3:0] NB_BIRTH_MIN = 4'd2;
  localparam logic [3:0] NB_BIRTH_MAX = 4'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET,
    OP_CLR,
    OP_STEP,
    OP_WIPE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic cell_value;
    logic done_res;
  } res_t;

  function automatic logic [3:0] count8(input logic [NB_COUNT-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  function automatic logic life_next(input logic self, input logic [3:0] n);
    return !self && (n >= NB_BIRTH_MIN) && (n <= NB_BIRTH_MAX);
  endfunction

endpackage

// ===== rtl/core/llga_fifo.sv =====
// small first-in first-out queue of flat words
module llga_fifo
  import llga_pkg::*;
#(
  parameter int WIDTH = $bits(cmd_t),
  parameter int DEPTH = CMD_Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/llga_front.sv =====
// command intake: decodes and range-checks words, queues them for the engine
module llga_front
  import llga_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ADDR_W-1:0] in_row,
  input  logic [ADDR_W-1:0] in_col,
  input  logic              hold,
  input  logic              q_pop,
  output logic              q_empty,
  output cmd_t              q_data
);

  logic                   addr_ok;
  cmd_t                   dec;
  logic                   q_full;
  logic [$bits(cmd_t)-1:0] q_rdata;

  assign addr_ok = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);

  always_comb begin
    dec.row = in_row;
    dec.col = in_col;
    unique case (in_cmd)
      CMD_SET:   dec.op = addr_ok ? OP_SET : OP_NOP;
      CMD_CLEAR: dec.op = addr_ok ? OP_CLR : OP_NOP;
      CMD_STEP:  dec.op = OP_STEP;
      CMD_WIPE:  dec.op = OP_WIPE;
      CMD_READ:  dec.op = addr_ok ? OP_READ : OP_NOP;
      default:   dec.op = OP_NOP;
    endcase
  end

  // nothing enters while the grid is being cleared after reset
  assign full = q_full || hold;

  llga_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && !hold),
    .wdata (dec),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_data = cmd_t'(q_rdata);

endmodule

// ===== rtl/core/llga_back.sv =====
// execution engine: row-wide grid memory, cell access, wipe and generation sweeps
module llga_back
  import llga_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty,
  input  cmd_t cmd_data,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res_data,
  output logic init_busy
);

  localparam int RW   = $clog2(GRID_ROWS);
  localparam int CLW  = $clog2(GRID_COLS);
  localparam int CNTW = $clog2(GRID_ROWS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_SWEEP,
    ST_STEP
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNTW-1:0]  rcnt_r, rcnt_nxt;
  logic             from_cmd_r, from_cmd_nxt;
  logic             init_r, init_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CLW-1:0]   col_r, col_nxt;
  logic             set_r, set_nxt;
  logic [GRID_COLS-1:0] up_r, up_nxt;
  logic [GRID_COLS-1:0] mid_r, mid_nxt;

  logic [GRID_COLS-1:0] grid_mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rdata_r;
  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [RW-1:0]        mem_raddr;
  logic [GRID_COLS-1:0] mem_wdata;
  logic [GRID_COLS-1:0] gen_row;
  logic [GRID_COLS-1:0] mod_row;

  // next generation of the middle row; rdata_r holds the row below it
  always_comb begin
    logic [NB_COUNT-1:0] nb;
    gen_row = mid_r;
    for (int c = 1; c < GRID_COLS - 1; c++) begin
      nb = {up_r[c-1], up_r[c], up_r[c+1], mid_r[c-1], mid_r[c+1],
            rdata_r[c-1], rdata_r[c], rdata_r[c+1]};
      gen_row[c] = life_next(mid_r[c], count8(nb));
    end
  end

  always_comb begin
    mod_row        = rdata_r;
    mod_row[col_r] = set_r;
  end

  always_comb begin
    state_nxt    = state_r;
    rcnt_nxt     = rcnt_r;
    from_cmd_nxt = from_cmd_r;
    init_nxt     = init_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    set_nxt      = set_r;
    up_nxt       = up_r;
    mid_nxt      = mid_r;
    mem_we       = 1'b0;
    mem_waddr    = row_r;
    mem_wdata    = mod_row;
    mem_raddr    = row_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_data.cell_value = 1'b0;
    res_data.done_res   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = RW'(cmd_data.row);
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          row_nxt = RW'(cmd_data.row);
          col_nxt = CLW'(cmd_data.col);
          rcnt_nxt = '0;
          unique case (cmd_data.op)
            OP_SET: begin
              set_nxt   = 1'b1;
              state_nxt = ST_MODIFY;
            end
            OP_CLR: begin
              set_nxt   = 1'b0;
              state_nxt = ST_MODIFY;
            end
            OP_READ: state_nxt = ST_READ;
            OP_WIPE: begin
              from_cmd_nxt = 1'b1;
              state_nxt    = ST_SWEEP;
            end
            OP_STEP: state_nxt = ST_STEP;
            default: res_push = 1'b1;
          endcase
        end
      end

      ST_READ: begin
        res_push            = 1'b1;
        res_data.cell_value = rdata_r[col_r];
        state_nxt           = ST_IDLE;
      end

      ST_MODIFY: begin
        mem_we    = 1'b1;
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = rcnt_r[RW-1:0];
        mem_wdata = '0;
        rcnt_nxt  = rcnt_r + CNTW'(1);
        if (rcnt_r == CNTW'(GRID_ROWS - 1)) begin
          res_push  = from_cmd_r;
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      ST_STEP: begin
        // row t is fetched while row t-1 arrives and row t-2 is written back
        mem_raddr = rcnt_r[RW-1:0];
        mem_waddr = RW'(rcnt_r - CNTW'(2));
        mem_wdata = gen_row;
        mem_we    = (rcnt_r >= CNTW'(3));
        rcnt_nxt  = rcnt_r + CNTW'(1);
        if (rcnt_r != '0) begin
          up_nxt  = mid_r;
          mid_nxt = rdata_r;
        end
        if (rcnt_r == CNTW'(GRID_ROWS)) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      rcnt_r     <= '0;
      from_cmd_r <= 1'b0;
      init_r     <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      rcnt_r     <= rcnt_nxt;
      from_cmd_r <= (state_nxt == ST_SWEEP) ? from_cmd_nxt : 1'b0;
      init_r     <= init_nxt;
    end
    row_r <= row_nxt;
    col_r <= col_nxt;
    set_r <= set_nxt;
    up_r  <= up_nxt;
    mid_r <= mid_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= grid_mem[mem_raddr];
  end

  assign init_busy = init_r;

endmodule

// ===== rtl/core/life_like_grid_automaton.sv =====
// top level of the life-like grid automaton
//
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------
// input    | push / full        | in_cmd[2:0], in_row[6:0], in_col[6:0]
// result   | empty / pop        | out_cell_value, out_done_res
//
// one result word per input word, in order. once a word leaves the command
// queue, a step sweeps the grid rows (one grid row read from the memory
// port per cycle), clear grid zeroes every row, set, clear and read touch
// one cell, and an off-grid address or an unused code yields a no-op. after
// reset the grid is zeroed one row a cycle with full held high. short
// queues on both sides let intake and result draining stall on their own.
module life_like_grid_automaton
  import llga_pkg::*;
#(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ADDR_W-1:0] in_row,
  input  logic [ADDR_W-1:0] in_col,
  output logic              empty,
  input  logic              pop,
  output logic              out_cell_value,
  output logic              out_done_res
);

  logic                    cmd_empty;
  logic                    cmd_pop;
  cmd_t                    cmd_data;
  logic                    init_busy;
  logic                    res_full;
  logic                    res_push;
  res_t                    res_data;
  logic [$bits(res_t)-1:0] res_rdata;
  res_t                    res_out;

  llga_front #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_cmd  (in_cmd),
    .in_row  (in_row),
    .in_col  (in_col),
    .hold    (init_busy),
    .q_pop   (cmd_pop),
    .q_empty (cmd_empty),
    .q_data  (cmd_data)
  );

  llga_back #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .init_busy (init_busy)
  );

  llga_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out        = res_t'(res_rdata);
  assign out_cell_value = res_out.cell_value;
  assign out_done_res   = res_out.done_res;

endmodule
